### rtl/core/tcw_pkg.sv
// Package for the text console writer: cell layout, operation and register
// codes, controller states and the result bundle. No dependencies.
package tcw_pkg;

  // Fixed field widths of the ports
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned RowPortW = 5;
  localparam int unsigned ColPortW = 7;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CellW    = CharW + 2 * ColorW;

  localparam logic [CharW-1:0]  NewlineChar = 8'd10;
  localparam logic [CharW-1:0]  BlankChar   = 8'd32;
  localparam logic [ColorW-1:0] FgReset     = 4'd15;
  localparam logic [ColorW-1:0] BgReset     = 4'd0;

  // Operation codes of an input transaction
  typedef enum logic [ModeW-1:0] {
    ModePut   = 2'd0,
    ModeClear = 2'd1,
    ModeHome  = 2'd2,
    ModeRead  = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFgColor = 1'b0,
    CfgBgColor = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScroll,
    StFlush,
    StClear
  } state_e;

  // One grid cell as stored: background in the top nibble, character at the bottom
  typedef struct packed {
    logic [ColorW-1:0] bg;
    logic [ColorW-1:0] fg;
    logic [CharW-1:0]  ch;
  } cell_t;

  // One result transaction
  typedef struct packed {
    logic                valid;
    logic [RowPortW-1:0] row;
    logic [ColPortW-1:0] col;
    logic [CharW-1:0]    ch;
    logic [ColorW-1:0]   fg;
    logic [ColorW-1:0]   bg;
  } result_t;

endpackage

### rtl/core/text_console_writer.sv
// Text console writer top level: colour registers, controller and cell store.
// Depends on tcw_pkg, tcw_cell_ram and tcw_ctrl.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start_i high
//   and busy_o low. mode_i selects put character, clear, home or read cell;
//   char_code_i is the put byte (newline moves the cursor only), read_row_i and
//   read_col_i address the cell for a read.
//   Result channel: done_o is high for exactly one cycle with the cursor and,
//   for a read, the cell contents. The receiver cannot stall; every command
//   gives one result.
//   Order to done_o: put and home go straight to the result register; a read
//   first passes the registered read port of the cell store; clear sweeps in
//   StClear; a put that scrolls sweeps in StScroll, then passes StFlush. Clear
//   and scroll walk the whole cell store through its single write port, one
//   cell a cycle; busy_o stays high until the result goes out.
//   Configuration: cfg_we_i writes cfg_wdata_i into the register at
//   cfg_idx_i (0 foreground, 1 background colour) at once; write only while idle.
//   Reset: cursor at row 0 column 0, foreground 15, background 0. The grid is
//   undefined until cleared or written.
module text_console_writer #(
  parameter int unsigned NUM_ROWS = 25,
  parameter int unsigned NUM_COLS = 80
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tcw_pkg::ModeW-1:0]     mode_i,
  input  logic [tcw_pkg::CharW-1:0]     char_code_i,
  input  logic [tcw_pkg::RowPortW-1:0]  read_row_i,
  input  logic [tcw_pkg::ColPortW-1:0]  read_col_i,
  output logic                          done_o,
  output logic [tcw_pkg::RowPortW-1:0]  cursor_row_o,
  output logic [tcw_pkg::ColPortW-1:0]  cursor_col_o,
  output logic [tcw_pkg::CharW-1:0]     cell_char_o,
  output logic [tcw_pkg::ColorW-1:0]    cell_fg_o,
  output logic [tcw_pkg::ColorW-1:0]    cell_bg_o,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcw_pkg::ColorW-1:0]    cfg_wdata_i
);

  localparam int unsigned CellCount = NUM_ROWS * NUM_COLS;
  localparam int unsigned AddrW     = $clog2(CellCount);

  logic [tcw_pkg::ColorW-1:0] fg_q, fg_d;
  logic [tcw_pkg::ColorW-1:0] bg_q, bg_d;

  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  tcw_pkg::cell_t             mem_wdata;
  logic                       mem_re;
  logic [AddrW-1:0]           mem_raddr;
  logic [tcw_pkg::CellW-1:0]  mem_rdata;
  tcw_pkg::result_t           res;

  // Decode configuration writes
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_we_i) begin
      unique case (tcw_pkg::cfg_reg_e'(cfg_idx_i))
        tcw_pkg::CfgFgColor: fg_d = cfg_wdata_i;
        tcw_pkg::CfgBgColor: bg_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FgReset;
      bg_q <= tcw_pkg::BgReset;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  tcw_ctrl #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .fg_i        (fg_q),
    .bg_i        (bg_q),
    .busy_o      (busy_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (tcw_pkg::cell_t'(mem_rdata)),
    .res_o       (res)
  );

  tcw_cell_ram #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Drive the result ports
  assign done_o       = res.valid;
  assign cursor_row_o = res.row;
  assign cursor_col_o = res.col;
  assign cell_char_o  = res.ch;
  assign cell_fg_o    = res.fg;
  assign cell_bg_o    = res.bg;

endmodule

### rtl/core/tcw_cell_ram.sv
// Cell store of the text console: single write port, single read port,
// registered read data. Depends on tcw_pkg for the cell width.
module tcw_cell_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [tcw_pkg::CellW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [tcw_pkg::CellW-1:0] rdata_o
);

  logic [tcw_pkg::CellW-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/tcw_ctrl.sv
// Controller of the text console: cursor, operation sequencer, scroll and
// clear sweeps over the cell store, result register. Depends on tcw_pkg.
module tcw_ctrl #(
  parameter int unsigned NUM_ROWS = 25,
  parameter int unsigned NUM_COLS = 80,
  parameter int unsigned AddrW    = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tcw_pkg::ModeW-1:0]     mode_i,
  input  logic [tcw_pkg::CharW-1:0]     char_code_i,
  input  logic [tcw_pkg::RowPortW-1:0]  read_row_i,
  input  logic [tcw_pkg::ColPortW-1:0]  read_col_i,
  input  logic [tcw_pkg::ColorW-1:0]    fg_i,
  input  logic [tcw_pkg::ColorW-1:0]    bg_i,
  output logic                          busy_o,
  output logic                          mem_we_o,
  output logic [AddrW-1:0]              mem_waddr_o,
  output tcw_pkg::cell_t                mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AddrW-1:0]              mem_raddr_o,
  input  tcw_pkg::cell_t                mem_rdata_i,
  output tcw_pkg::result_t              res_o
);

  localparam int unsigned CellCount = NUM_ROWS * NUM_COLS;
  localparam int unsigned RowW      = $clog2(NUM_ROWS);
  localparam int unsigned ColW      = $clog2(NUM_COLS);

  tcw_pkg::state_e  state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] sw_q, sw_d;
  logic             rd_ok_q, rd_ok_d;
  logic             wr_v_q, wr_v_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic             wr_copy_q, wr_copy_d;
  tcw_pkg::result_t res_q, res_d;

  logic             accept;
  logic             last_row;
  logic             last_col;
  logic             sw_last;
  logic             sw_copy;
  logic             fin;
  tcw_pkg::cell_t   blank;
  tcw_pkg::cell_t   fin_cell;
  logic [RowW+4:0]  row_ext;
  logic [ColW+6:0]  col_ext;

  assign busy_o   = (state_q != tcw_pkg::StIdle);
  assign accept   = start_i && !busy_o;
  assign last_row = (row_q == RowW'(NUM_ROWS - 1));
  assign last_col = (col_q == ColW'(NUM_COLS - 1));
  assign sw_last  = (sw_q == AddrW'(CellCount - 1));
  assign sw_copy  = (int'(sw_q) < int'(CellCount - NUM_COLS));
  assign blank    = '{bg: bg_i, fg: fg_i, ch: tcw_pkg::BlankChar};
  assign row_ext  = {5'd0, row_d};
  assign col_ext  = {7'd0, col_d};

  // Sequence operations and drive the cell store
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    sw_d        = sw_q;
    rd_ok_d     = rd_ok_q;
    wr_v_d      = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_copy_d   = wr_copy_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = blank;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    fin         = 1'b0;
    fin_cell    = '0;

    // Retire the delayed write of a scroll copy or bottom-row blank
    if (wr_v_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wr_addr_q;
      mem_wdata_o = wr_copy_q ? mem_rdata_i : blank;
    end

    unique case (state_q)
      tcw_pkg::StIdle: begin
        if (accept) begin
          unique case (tcw_pkg::mode_e'(mode_i))
            tcw_pkg::ModePut: begin
              if (char_code_i == tcw_pkg::NewlineChar) begin
                col_d = '0;
                if (last_row) begin
                  sw_d    = '0;
                  state_d = tcw_pkg::StScroll;
                end else begin
                  row_d = row_q + RowW'(1);
                  fin   = 1'b1;
                end
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrW'(int'(row_q) * NUM_COLS + int'(col_q));
                mem_wdata_o = '{bg: bg_i, fg: fg_i, ch: char_code_i};
                if (!last_col) begin
                  col_d = col_q + ColW'(1);
                  fin   = 1'b1;
                end else begin
                  col_d = '0;
                  if (last_row) begin
                    sw_d    = '0;
                    state_d = tcw_pkg::StScroll;
                  end else begin
                    row_d = row_q + RowW'(1);
                    fin   = 1'b1;
                  end
                end
              end
            end
            tcw_pkg::ModeClear: begin
              row_d   = '0;
              col_d   = '0;
              sw_d    = '0;
              state_d = tcw_pkg::StClear;
            end
            tcw_pkg::ModeHome: begin
              row_d = '0;
              col_d = '0;
              fin   = 1'b1;
            end
            tcw_pkg::ModeRead: begin
              rd_ok_d     = (int'(read_row_i) < int'(NUM_ROWS)) &&
                            (int'(read_col_i) < int'(NUM_COLS));
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrW'(int'(read_row_i) * NUM_COLS + int'(read_col_i));
              state_d     = tcw_pkg::StRead;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::StRead: begin
        fin      = 1'b1;
        fin_cell = rd_ok_q ? mem_rdata_i : '0;
        state_d  = tcw_pkg::StIdle;
      end
      tcw_pkg::StScroll: begin
        // Read one row below, write it back next cycle one row up
        mem_re_o    = sw_copy;
        mem_raddr_o = AddrW'(int'(sw_q) + NUM_COLS);
        wr_v_d      = 1'b1;
        wr_addr_d   = sw_q;
        wr_copy_d   = sw_copy;
        if (sw_last) begin
          state_d = tcw_pkg::StFlush;
        end else begin
          sw_d = sw_q + AddrW'(1);
        end
      end
      tcw_pkg::StFlush: begin
        fin     = 1'b1;
        state_d = tcw_pkg::StIdle;
      end
      tcw_pkg::StClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sw_q;
        mem_wdata_o = blank;
        if (sw_last) begin
          fin     = 1'b1;
          state_d = tcw_pkg::StIdle;
        end else begin
          sw_d = sw_q + AddrW'(1);
        end
      end
      default: state_d = tcw_pkg::StIdle;
    endcase
  end

  // Build the result transaction
  always_comb begin
    res_d       = res_q;
    res_d.valid = fin;
    if (fin) begin
      res_d.row = row_ext[4:0];
      res_d.col = col_ext[6:0];
      res_d.ch  = fin_cell.ch;
      res_d.fg  = fin_cell.fg;
      res_d.bg  = fin_cell.bg;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::StIdle;
      row_q   <= '0;
      col_q   <= '0;
      wr_v_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      wr_v_q  <= wr_v_d;
      res_q   <= res_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sw_q      <= sw_d;
    rd_ok_q   <= rd_ok_d;
    wr_addr_q <= wr_addr_d;
    wr_copy_q <= wr_copy_d;
  end

  assign res_o = res_q;

  // Checks
  a_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < int'(NUM_ROWS)) && (int'(col_q) < int'(NUM_COLS)))
    else $error("cursor left the grid");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == tcw_pkg::ModeRead) |-> ##2 res_q.valid)
    else $error("read transaction gave no result two cycles later");

  a_put_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == tcw_pkg::ModePut) && (char_code_i != tcw_pkg::NewlineChar)
    |-> mem_we_o)
    else $error("put of a character did not write the cell store");

  a_delayed_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> (state_q == tcw_pkg::StScroll) || (state_q == tcw_pkg::StFlush))
    else $error("delayed write outside a scroll");

  a_home_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == tcw_pkg::ModeHome)
    |=> res_q.valid && (res_q.row == '0) && (res_q.col == '0))
    else $error("home did not report the cursor at the origin");

endmodule
